// ===== design/brb_pkg.sv =====
// Shared constants, types and helper functions for the byte ring buffer.
`default_nettype none

package brb_pkg;

    localparam int DEPTH    = 1024;
    localparam int MAX_PUSH = 8;
    localparam int MAX_POP  = 64;

    localparam int PTR_W   = $clog2(DEPTH);
    localparam int SIZE_W  = PTR_W + 1;
    localparam int CFG_W   = 11;
    localparam int BYTES_W = 64;
    localparam int CNT_W   = 4;
    localparam int POP_W   = 7;
    localparam int KIND_W  = 2;

    localparam int Q_DEPTH = 2;
    localparam int Q_IDX_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    localparam logic [KIND_W-1:0] KIND_ACK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd2;

    typedef struct packed {
        logic               is_pop;
        logic [BYTES_W-1:0] bytes;
        logic [CNT_W-1:0]   count;
        logic               count_ok;
        logic [POP_W-1:0]   pop_max;
    } t_cmd;

    function automatic logic [SIZE_W-1:0] size_clamp(input logic [CFG_W-1:0] v);
        logic [SIZE_W-1:0] res;
        if (v < CFG_W'(2)) begin
            res = SIZE_W'(2);
        end else if (v > CFG_W'(DEPTH)) begin
            res = SIZE_W'(DEPTH);
        end else begin
            res = SIZE_W'(v);
        end
        return res;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p,
                                                  input logic [SIZE_W-1:0] n);
        logic [PTR_W-1:0] res;
        if ((SIZE_W'(p) + SIZE_W'(1)) >= n) begin
            res = '0;
        end else begin
            res = p + PTR_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== design/brb_front.sv =====
// Front end: classify incoming beats and hold them in a short command queue.
`default_nettype none

module brb_front (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_func,
    input  wire logic [brb_pkg::BYTES_W-1:0]   i_push_bytes,
    input  wire logic [brb_pkg::CNT_W-1:0]     i_push_count,
    input  wire logic [brb_pkg::POP_W-1:0]     i_pop_max,
    output logic                               o_cmd_valid,
    output brb_pkg::t_cmd                      o_cmd,
    input  wire logic                          i_cmd_take
);

    brb_pkg::t_cmd                      r_q [brb_pkg::Q_DEPTH];
    logic [brb_pkg::Q_IDX_W-1:0]        r_wr;
    logic [brb_pkg::Q_IDX_W-1:0]        r_rd;
    logic [brb_pkg::Q_CNT_W-1:0]        r_cnt;
    brb_pkg::t_cmd                      n_cmd;
    logic                               n_push;
    logic                               n_pop;

    always_comb begin
        n_cmd.is_pop   = (i_func == brb_pkg::FUNC_POP);
        n_cmd.bytes    = i_push_bytes;
        n_cmd.count    = i_push_count;
        n_cmd.count_ok = (i_push_count != '0) &&
                         (i_push_count <= brb_pkg::CNT_W'(brb_pkg::MAX_PUSH));
        n_cmd.pop_max  = (i_pop_max > brb_pkg::POP_W'(brb_pkg::MAX_POP)) ?
                         brb_pkg::POP_W'(brb_pkg::MAX_POP) : i_pop_max;
    end

    assign o_in_stall  = (r_cnt == brb_pkg::Q_CNT_W'(brb_pkg::Q_DEPTH));
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];
    assign n_push      = i_in_valid && !o_in_stall;
    assign n_pop       = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_q[r_wr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (n_push) begin
                r_wr <= r_wr + brb_pkg::Q_IDX_W'(1);
            end
            if (n_pop) begin
                r_rd <= r_rd + brb_pkg::Q_IDX_W'(1);
            end
            if (n_push && !n_pop) begin
                r_cnt <= r_cnt + brb_pkg::Q_CNT_W'(1);
            end else if (n_pop && !n_push) begin
                r_cnt <= r_cnt - brb_pkg::Q_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/brb_back.sv =====
// Back end: ring storage, pointers and the sequencer that produces result beats.
`default_nettype none

module brb_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [brb_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_cmd_valid,
    input  wire brb_pkg::t_cmd                 i_cmd,
    output logic                               o_cmd_take,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [brb_pkg::KIND_W-1:0]         o_kind,
    output logic                               o_accepted,
    output logic [7:0]                         o_byte_out,
    output logic                               o_last,
    output logic [brb_pkg::PTR_W-1:0]          o_used_space,
    output logic [brb_pkg::PTR_W-1:0]          o_free_space
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_ACK,
        S_POUT,
        S_PWAIT
    } t_state;

    t_state                             r_state;
    logic [brb_pkg::SIZE_W-1:0]         r_size;
    logic [brb_pkg::PTR_W-1:0]          r_wp;
    logic [brb_pkg::PTR_W-1:0]          r_rp;
    logic [brb_pkg::PTR_W-1:0]          r_used;
    logic [brb_pkg::BYTES_W-1:0]        r_bytes;
    logic [brb_pkg::CNT_W-1:0]          r_cnt;
    logic [brb_pkg::POP_W-1:0]          r_left;
    logic [brb_pkg::KIND_W-1:0]         r_kind;
    logic                               r_acc;
    logic [7:0]                         r_mem [brb_pkg::DEPTH];
    logic [7:0]                         r_rdata;
    logic                               r_ovalid;

    logic                               n_slot;
    logic [brb_pkg::PTR_W-1:0]          n_free;
    logic [brb_pkg::PTR_W-1:0]          n_free_pop;
    logic [brb_pkg::POP_W-1:0]          n_take;
    logic                               n_fits;

    assign n_slot     = !r_ovalid || !i_out_stall;
    assign n_free     = brb_pkg::PTR_W'(r_size - brb_pkg::SIZE_W'(1)
                                        - brb_pkg::SIZE_W'(r_used));
    assign n_free_pop = brb_pkg::PTR_W'(r_size - brb_pkg::SIZE_W'(r_used));
    assign n_take     = (r_used < brb_pkg::PTR_W'(i_cmd.pop_max)) ?
                        brb_pkg::POP_W'(r_used) : i_cmd.pop_max;
    assign n_fits     = i_cmd.count_ok && (brb_pkg::PTR_W'(i_cmd.count) <= n_free);
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid;
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_mem[r_wp] <= r_bytes[7:0];
        end
        r_rdata <= r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= brb_pkg::SIZE_W'(brb_pkg::DEPTH);
            r_wp     <= '0;
            r_rp     <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_size <= brb_pkg::size_clamp(i_cfg_data);
                r_wp   <= '0;
                r_rp   <= '0;
                r_used <= '0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.is_pop) begin
                            if (n_take == '0) begin
                                r_kind  <= brb_pkg::KIND_NONE;
                                r_acc   <= 1'b0;
                                r_state <= S_ACK;
                            end else begin
                                r_left  <= n_take;
                                r_state <= S_POUT;
                            end
                        end else if (n_fits) begin
                            r_bytes <= i_cmd.bytes;
                            r_cnt   <= i_cmd.count;
                            r_kind  <= brb_pkg::KIND_ACK;
                            r_acc   <= 1'b1;
                            r_state <= S_WRITE;
                        end else begin
                            r_kind  <= brb_pkg::KIND_ACK;
                            r_acc   <= 1'b0;
                            r_state <= S_ACK;
                        end
                    end
                end
                S_WRITE: begin
                    r_wp    <= brb_pkg::ptr_next(r_wp, r_size);
                    r_used  <= r_used + brb_pkg::PTR_W'(1);
                    r_bytes <= r_bytes >> 8;
                    r_cnt   <= r_cnt - brb_pkg::CNT_W'(1);
                    if (r_cnt == brb_pkg::CNT_W'(1)) begin
                        r_state <= S_ACK;
                    end
                end
                S_ACK: begin
                    if (n_slot) begin
                        r_ovalid     <= 1'b1;
                        o_kind       <= r_kind;
                        o_accepted   <= r_acc;
                        o_byte_out   <= '0;
                        o_last       <= 1'b1;
                        o_used_space <= r_used;
                        o_free_space <= n_free;
                        r_state      <= S_IDLE;
                    end
                end
                S_POUT: begin
                    if (n_slot) begin
                        r_ovalid     <= 1'b1;
                        o_kind       <= brb_pkg::KIND_BYTE;
                        o_accepted   <= 1'b0;
                        o_byte_out   <= r_rdata;
                        o_last       <= (r_left == brb_pkg::POP_W'(1));
                        o_used_space <= r_used - brb_pkg::PTR_W'(1);
                        o_free_space <= n_free_pop;
                        r_rp         <= brb_pkg::ptr_next(r_rp, r_size);
                        r_used       <= r_used - brb_pkg::PTR_W'(1);
                        r_left       <= r_left - brb_pkg::POP_W'(1);
                        r_state      <= (r_left == brb_pkg::POP_W'(1)) ? S_IDLE : S_PWAIT;
                    end
                end
                S_PWAIT: begin
                    r_state <= S_POUT;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== design/byte_ring_buffer_burst.sv =====
// Top level of the byte ring buffer with burst push and streaming pop.
// Push of n bytes: the command is dequeued, the n bytes are written to the ring in turn, then the ack is presented.
// Pop of k bytes: the command is dequeued, then each byte beat is presented, with a wait state between beats.
// Rejected push or empty pop: dequeue, then present the single beat. A two-entry command queue decouples input.
// Synchronous active-low reset empties the ring, sets ring_size to 1024, drops all beats.
`default_nettype none

module byte_ring_buffer_burst (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [brb_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic                          i_func,
    input  wire logic [brb_pkg::BYTES_W-1:0]   i_push_bytes,
    input  wire logic [brb_pkg::CNT_W-1:0]     i_push_count,
    input  wire logic [brb_pkg::POP_W-1:0]     i_pop_max,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [brb_pkg::KIND_W-1:0]         o_kind,
    output logic                               o_accepted,
    output logic [7:0]                         o_byte_out,
    output logic                               o_last,
    output logic [brb_pkg::PTR_W-1:0]          o_used_space,
    output logic [brb_pkg::PTR_W-1:0]          o_free_space
);

    logic          w_cmd_valid;
    logic          w_cmd_take;
    brb_pkg::t_cmd w_cmd;

    brb_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_func       (i_func),
        .i_push_bytes (i_push_bytes),
        .i_push_count (i_push_count),
        .i_pop_max    (i_pop_max),
        .o_cmd_valid  (w_cmd_valid),
        .o_cmd        (w_cmd),
        .i_cmd_take   (w_cmd_take)
    );

    brb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_cmd_valid  (w_cmd_valid),
        .i_cmd        (w_cmd),
        .o_cmd_take   (w_cmd_take),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_accepted   (o_accepted),
        .o_byte_out   (o_byte_out),
        .o_last       (o_last),
        .o_used_space (o_used_space),
        .o_free_space (o_free_space)
    );

endmodule

`default_nettype wire

// ===== design/brb_checker.sv =====
// Port-level checker for the byte ring buffer, bound to the top level.
`default_nettype none

module brb_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [brb_pkg::KIND_W-1:0]    o_kind,
    input  wire logic                          o_accepted,
    input  wire logic [7:0]                    o_byte_out,
    input  wire logic                          o_last,
    input  wire logic [brb_pkg::PTR_W-1:0]     o_used_space,
    input  wire logic [brb_pkg::PTR_W-1:0]     o_free_space
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid right after reset");

    a_single_beat_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == brb_pkg::KIND_ACK || o_kind == brb_pkg::KIND_NONE)
        |-> o_last)
        else $error("ack or empty-pop beat without last");

    a_pop_not_accepted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind != brb_pkg::KIND_ACK |-> !o_accepted)
        else $error("pop beat flagged accepted");

    a_space_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ({1'b0, o_used_space} + {1'b0, o_free_space})
                        <= (brb_pkg::SIZE_W)'(brb_pkg::DEPTH - 1))
        else $error("used plus free exceeds ring capacity");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_kind)
                                       && $stable(o_byte_out) && $stable(o_last))
        else $error("stalled result beat changed");

endmodule

bind byte_ring_buffer_burst brb_checker u_brb_checker (.*);

`default_nettype wire
